[hdl/fbme_pkg.sv]
// Shared constants, types and codes of the median background estimator.
// No dependencies; every other file in the block imports this package.
package fbme_pkg;

  localparam int MAX_PIXELS  = 524288;
  localparam int FRAC_BITS   = 8;
  localparam int ADDR_W      = $clog2(MAX_PIXELS);
  localparam int FIX_W       = 16;
  localparam int PIX_W       = 8;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 9;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 10;
  localparam int PROD_W      = WIDTH_W + ROW_W;
  localparam int SUM_W       = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int BACK_STAGES = 4;

  localparam logic [WIDTH_W-1:0]  MAX_WIDTH  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = HEIGHT_W'(512);

  localparam logic [FIX_W-1:0]    RST_MIN_STEP     = FIX_W'(256);
  localparam logic [FIX_W-1:0]    RST_EPSILON_GAIN = FIX_W'(655);
  localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = HEIGHT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_STEP     = 2'd0,
    CFG_EPSILON_GAIN = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FIX_W-1:0]    min_step;
    logic [FIX_W-1:0]    epsilon_gain;
    logic [WIDTH_W-1:0]  frame_width;
    logic [HEIGHT_W-1:0] frame_height;
  } cfg_t;

  // One classified pixel on its way from the front end to the update pipeline.
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic              frame_end;
    logic              primed;
  } job_t;

endpackage

[hdl/fbme_if.sv]
// Valid/ready channels of the median background estimator: pixels in,
// results out, configuration writes. Depends on fbme_pkg.
interface fbme_pix_if import fbme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface fbme_res_if import fbme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] background;
  logic             frame_end;
  modport source (output valid, output background, output frame_end, input ready);
  modport sink   (input valid, input background, input frame_end, output ready);
endinterface

interface fbme_cfg_if import fbme_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/fbme_front.sv]
// Front end: accepts pixels, tracks raster position and priming, and forms
// the store address of each pixel. Depends on fbme_pkg and fbme_if.
module fbme_front import fbme_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  fbme_pix_if.sink pixels,
  input  logic   q_full,
  output logic   push,
  output job_t   job
);

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic                primed;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [SUM_W-1:0]    row_base;
  logic [SUM_W-1:0]    addr_full;
  logic                row_end;
  logic                frame_end;

  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (cfg.frame_width > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end else begin
      w_eff = cfg.frame_width;
    end
    if (cfg.frame_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (cfg.frame_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = cfg.frame_height;
    end
  end

  assign row_base  = SUM_W'(row_count) * SUM_W'(w_eff);
  assign addr_full = row_base + SUM_W'(column_count);
  assign row_end   = (WIDTH_W'(column_count) + WIDTH_W'(1)) >= w_eff;
  assign frame_end = row_end && ((HEIGHT_W'(row_count) + HEIGHT_W'(1)) >= h_eff);

  assign pixels.ready = !q_full;
  assign push         = pixels.valid && !q_full;

  assign job.pixel     = pixels.pixel;
  assign job.addr      = addr_full[ADDR_W-1:0];
  assign job.frame_end = frame_end;
  assign job.primed    = primed;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      primed       <= 1'b0;
    end else if (push) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
      if (frame_end) begin
        primed <= 1'b1;
      end
    end
  end

endmodule

[hdl/fbme_queue.sv]
// Short job queue between the front end and the update pipeline.
// Depends on fbme_pkg.
module fbme_queue import fbme_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[hdl/fbme_back.sv]
// Update pipeline: reads background and step of each pixel, moves the
// background, adapts the step, writes both back and rounds the result.
// Depends on fbme_pkg and fbme_if.
module fbme_back import fbme_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  job_t head,
  output logic pop,
  fbme_res_if.source results
);

  localparam int INT_W = FIX_W - FRAC_BITS;
  localparam int WIDE_W = PIX_W + FRAC_BITS + 1;
  localparam logic [FIX_W-1:0] FIX_MAX = {FIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  function automatic logic [FIX_W-1:0] to_fixed(input logic [PIX_W-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v) << FRAC_BITS;
    return (wide > WIDE_W'(FIX_MAX)) ? FIX_MAX : wide[FIX_W-1:0];
  endfunction

  logic [2*FIX_W-1:0] store [MAX_PIXELS];
  logic [2*FIX_W-1:0] rd_data;

  logic adv;
  logic hazard;

  // stage 1: job plus stored entry
  logic             r1_valid;
  job_t             r1_job;
  logic [FIX_W-1:0] p1;
  logic [FIX_W-1:0] s0;
  logic [FIX_W-1:0] st0;
  logic [FIX_W-1:0] bg_rd;
  logic [FIX_W-1:0] st_rd;
  logic [FIX_W:0]   bg_sum;
  logic [FIX_W-1:0] bg_up;
  logic [FIX_W-1:0] s1_bg;
  logic [FIX_W-1:0] s1_st;

  // stage 2: moved background, step before halving
  logic              r2_valid;
  logic [ADDR_W-1:0] r2_addr;
  logic              r2_frame_end;
  logic              r2_primed;
  logic [FIX_W-1:0]  r2_p;
  logic [FIX_W-1:0]  r2_bg;
  logic [FIX_W-1:0]  r2_st;
  logic [FIX_W-1:0]  gap;
  logic [FIX_W-1:0]  s2_st;

  // stage 3: step growth, write back, rounding
  logic                r3_valid;
  logic [ADDR_W-1:0]   r3_addr;
  logic                r3_frame_end;
  logic                r3_primed;
  logic [FIX_W-1:0]    r3_bg;
  logic [FIX_W-1:0]    r3_st;
  logic [2*FIX_W-1:0]  prod;
  logic [FIX_W:0]      st_grown;
  logic [FIX_W-1:0]    st_fin;
  logic [FRAC_BITS-1:0] frac;
  logic                round_up;
  logic [INT_W:0]      q_rnd;
  logic [PIX_W-1:0]    bg_out;

  // stage 4: output register
  logic             r4_valid;
  logic [PIX_W-1:0] r4_bg;
  logic             r4_frame_end;

  assign adv = !r4_valid || results.ready;

  // hold a job back while an older job for the same entry has not written it
  assign hazard = (r1_valid && r1_job.addr == head.addr) ||
                  (r2_valid && r2_addr == head.addr) ||
                  (r3_valid && r3_addr == head.addr);
  assign pop = adv && !q_empty && !hazard;

  always_comb begin
    p1    = to_fixed(r1_job.pixel);
    s0    = to_fixed(r1_job.pixel >> 1);
    st0   = (s0 < cfg.min_step) ? cfg.min_step : s0;
    bg_rd = rd_data[2*FIX_W-1:FIX_W];
    st_rd = rd_data[FIX_W-1:0];
    bg_sum = {1'b0, bg_rd} + {1'b0, st_rd};
    if (bg_rd > p1) begin
      bg_up = (bg_rd > st_rd) ? bg_rd - st_rd : '0;
    end else if (bg_rd < p1) begin
      bg_up = bg_sum[FIX_W] ? FIX_MAX : bg_sum[FIX_W-1:0];
    end else begin
      bg_up = bg_rd;
    end
    s1_bg = r1_job.primed ? bg_up : p1;
    s1_st = r1_job.primed ? st_rd : st0;
  end

  always_comb begin
    gap   = (r2_p > r2_bg) ? r2_p - r2_bg : r2_bg - r2_p;
    s2_st = (r2_primed && gap < r2_st) ? r2_st >> 1 : r2_st;
  end

  always_comb begin
    // st * (1 + eps) truncated equals st + (st * eps) >> 16
    prod     = r3_st * cfg.epsilon_gain;
    st_grown = {1'b0, r3_st} + {1'b0, prod[2*FIX_W-1:FIX_W]};
    if (!r3_primed) begin
      st_fin = r3_st;
    end else begin
      st_fin = st_grown[FIX_W] ? FIX_MAX : st_grown[FIX_W-1:0];
    end
    frac     = r3_bg[FRAC_BITS-1:0];
    round_up = (frac > HALF) || (frac == HALF && r3_bg[FRAC_BITS]);
    q_rnd    = (INT_W+1)'(r3_bg >> FRAC_BITS) + (INT_W+1)'(round_up);
    bg_out   = (q_rnd > (INT_W+1)'(PIX_MAX)) ? PIX_MAX : PIX_W'(q_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
      r4_valid <= 1'b0;
    end else if (adv) begin
      r1_valid <= pop;
      r2_valid <= r1_valid;
      r3_valid <= r2_valid;
      r4_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_job       <= head;
      r2_addr      <= r1_job.addr;
      r2_frame_end <= r1_job.frame_end;
      r2_primed    <= r1_job.primed;
      r2_p         <= p1;
      r2_bg        <= s1_bg;
      r2_st        <= s1_st;
      r3_addr      <= r2_addr;
      r3_frame_end <= r2_frame_end;
      r3_primed    <= r2_primed;
      r3_bg        <= r2_bg;
      r3_st        <= s2_st;
      r4_bg        <= bg_out;
      r4_frame_end <= r3_frame_end;
    end
  end

  // entry store: read-first, one read and one write port
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= store[head.addr];
    end
    if (adv && r3_valid) begin
      store[r3_addr] <= {r3_bg, st_fin};
    end
  end

  assign results.valid      = r4_valid;
  assign results.background = r4_bg;
  assign results.frame_end  = r4_frame_end;

endmodule

[hdl/fame_background_median_estimator.sv]
// Top level of the per-pixel running-median background estimator.
// Depends on fbme_pkg, fbme_if, fbme_front, fbme_queue and fbme_back.
//
// Usage:
//   pixels  : one 8-bit grey pixel per beat, raster order, frame after frame.
//   results : one beat per pixel with the rounded background of that pixel
//             and frame_end set on the last pixel of each frame.
//   cfg     : register writes (min_step, epsilon_gain, frame_width,
//             frame_height); always ready. Write only while no pixel is in
//             flight.
//   Throughput is one pixel per cycle. The store of background and step has
//   a single read and a single write port, and an update takes three
//   pipeline stages before write-back, so frames of fewer than four pixels
//   hold a pixel until the previous write of its entry is done.
//   A pixel beat passes the job queue and each pipeline stage up to the
//   output register before result valid rises.
//   Reset clears the raster counters and restarts priming: the first frame
//   after reset loads the store; registers return to their defaults. The
//   store itself is not cleared.
//   When results stall, the pipeline holds and a four-entry job queue fills;
//   pixels ready drops once it is full, and no beat is lost.
module fame_background_median_estimator import fbme_pkg::*; (
  input  logic clk,
  input  logic rst,
  fbme_pix_if.sink   pixels,
  fbme_res_if.source results,
  fbme_cfg_if.sink   cfg
);

  logic [FIX_W-1:0]    min_step;
  logic [FIX_W-1:0]    epsilon_gain;
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  cfg_t                settings;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step     <= RST_MIN_STEP;
      epsilon_gain <= RST_EPSILON_GAIN;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_STEP:     min_step     <= cfg.data[FIX_W-1:0];
        CFG_EPSILON_GAIN: epsilon_gain <= cfg.data[FIX_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign settings.min_step     = min_step;
  assign settings.epsilon_gain = epsilon_gain;
  assign settings.frame_width  = frame_width;
  assign settings.frame_height = frame_height;

  fbme_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (settings),
    .pixels (pixels),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  fbme_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  fbme_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (settings),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

[hdl/fbme_checker.sv]
// Port-level checks of the median background estimator and their binding.
// Depends on fbme_pkg and the top level fame_background_median_estimator.
module fbme_checker import fbme_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pix_valid,
  input logic             pix_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [PIX_W-1:0] res_background,
  input logic             res_frame_end
);

  localparam int CAPACITY = QUEUE_DEPTH + BACK_STAGES;
  localparam int PEND_W   = $clog2(CAPACITY + 1) + 1;

  logic              in_beat;
  logic              out_beat;
  logic [PEND_W-1:0] pending;

  assign in_beat  = pix_valid && pix_ready;
  assign out_beat = res_valid && res_ready;

  // count pixels taken whose results are not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   pending <= pending + PEND_W'(1);
        2'b01:   pending <= pending - PEND_W'(1);
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_background) &&
                                $stable(res_frame_end))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != '0)
    else $error("result offered with no pixel outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending == PEND_W'(CAPACITY) |-> !pix_ready)
    else $error("pixel ready with every slot occupied");

endmodule

bind fame_background_median_estimator fbme_checker u_fbme_checker (
  .clk            (clk),
  .rst            (rst),
  .pix_valid      (pixels.valid),
  .pix_ready      (pixels.ready),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_background (results.background),
  .res_frame_end  (results.frame_end)
);

[verif/tb_fame_background_median_estimator.sv]
`timescale 1ns / 100ps
// Testbench of fame_background_median_estimator. A behavioral predictor
// checks every result beat. Depends on fbme_pkg, fbme_if and the block's RTL.
module tb_fame_background_median_estimator;
  import fbme_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PIXELS = 820;
  localparam int PRIME_W       = 16;
  localparam int PRIME_H       = 16;
  localparam int SCENE_SIZE    = PRIME_W * PRIME_H;
  localparam int TAIL_CYCLES   = 20;
  localparam int COL_MASK      = (1 << COL_W) - 1;
  localparam int ROW_MASK      = (1 << ROW_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] background;
    logic             frame_end;
  } bg_beat_t;

  logic clk;
  logic rst;

  fbme_pix_if pix_bus ();
  fbme_res_if res_bus ();
  fbme_cfg_if cfg_bus ();

  fame_background_median_estimator u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_bus),
    .results (res_bus),
    .cfg     (cfg_bus)
  );

  // predictor state: per-pixel background and step, raster counters, registers
  bit [FIX_W-1:0] bg_mem   [MAX_PIXELS];
  bit [FIX_W-1:0] step_mem [MAX_PIXELS];
  bit             seen_mem [MAX_PIXELS];
  int unsigned    col_pos;
  int unsigned    row_pos;
  bit             primed_flag;
  int unsigned    min_step_r;
  int unsigned    eps_gain_r;
  int unsigned    width_r;
  int unsigned    height_r;
  bg_beat_t       bg_expect [$];

  logic [PIX_W-1:0] scene [SCENE_SIZE];

  int  errors;
  int  pixels_sent;
  int  beats_checked;
  int  frames_checked;
  int  reg_writes;
  int  tie_hits;
  int  sat_hits;
  int  stalled_cycles;
  int  cycle_count;
  int  hold_left;
  int  stall_left;
  bit  idle_on;
  bit  tail_mode;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned eff_width(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  function automatic int unsigned eff_height(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MAX_HEIGHT) return MAX_HEIGHT;
    return raw;
  endfunction

  function automatic int unsigned clip16(longint unsigned v);
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] round_background(int unsigned fix);
    int unsigned whole;
    int unsigned frac;
    int unsigned half;
    whole = fix >> FRAC_BITS;
    frac  = fix & ((1 << FRAC_BITS) - 1);
    half  = 1 << (FRAC_BITS - 1);
    // ties go to the even grey level
    if (frac > half || (frac == half && (whole & 1) != 0)) whole++;
    return (whole > 255) ? 8'd255 : PIX_W'(whole);
  endfunction

  function automatic bg_beat_t update_background(logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    int unsigned p;
    int unsigned bg;
    int unsigned st;
    int unsigned seed;
    int unsigned gap;
    bit          row_end;
    bg_beat_t    beat;
    w    = eff_width(width_r);
    h    = eff_height(height_r);
    addr = (row_pos * w + col_pos) % MAX_PIXELS;
    p    = clip16(64'(pix) << FRAC_BITS);
    if (!primed_flag) begin
      seed = clip16(64'(pix >> 1) << FRAC_BITS);
      bg   = p;
      st   = (seed < min_step_r) ? min_step_r : seed;
    end else begin
      bg = bg_mem[addr];
      st = step_mem[addr];
      if (bg > p) bg = (bg > st) ? bg - st : 0;
      else if (bg < p) bg = clip16(64'(bg) + st);
      gap = (p > bg) ? p - bg : bg - p;
      if (gap < st) st = st >> 1;
      st = clip16((64'(st) * (65536 + eps_gain_r)) >> 16);
      if (bg == 0 || bg == 65535) sat_hits++;
    end
    if ((bg & ((1 << FRAC_BITS) - 1)) == (1 << (FRAC_BITS - 1))) tie_hits++;
    bg_mem[addr]   = FIX_W'(bg);
    step_mem[addr] = FIX_W'(st);
    seen_mem[addr] = 1'b1;

    row_end        = (col_pos + 1 >= w);
    beat.frame_end = row_end && (row_pos + 1 >= h);
    if (row_end) begin
      col_pos = 0;
      row_pos = beat.frame_end ? 0 : ((row_pos + 1) & ROW_MASK);
    end else begin
      col_pos = (col_pos + 1) & COL_MASK;
    end
    if (beat.frame_end) primed_flag = 1'b1;
    beat.background = round_background(bg);
    return beat;
  endfunction

  // A size is usable when the rest of the current frame and every full frame
  // after it touch only entries the store already holds.
  function automatic bit sizes_are_safe(int unsigned w_raw, int unsigned h_raw);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned a;
    bit          done;
    w = eff_width(w_raw);
    h = eff_height(h_raw);
    if (!primed_flag) return 1'b1;
    if (w * h > MAX_PIXELS) return 1'b0;
    for (a = 0; a < w * h; a++)
      if (!seen_mem[a]) return 1'b0;
    c    = col_pos;
    r    = row_pos;
    done = 1'b0;
    while (!done) begin
      if (!seen_mem[(r * w + c) % MAX_PIXELS]) return 1'b0;
      if (c + 1 >= w) begin
        done = (r + 1 >= h);
        c    = 0;
        r    = (r + 1) & ROW_MASK;
      end else begin
        c = (c + 1) & COL_MASK;
      end
    end
    return 1'b1;
  endfunction

  // scene value of the entry the next pixel lands on, with noise and outliers
  function automatic logic [PIX_W-1:0] scene_pixel(int noise);
    int unsigned a;
    int          v;
    a = ((row_pos * eff_width(width_r) + col_pos) % MAX_PIXELS) % SCENE_SIZE;
    if ($urandom_range(0, 9) == 0) return PIX_W'($urandom);
    v = int'(scene[a]) + int'($urandom_range(0, 2 * noise)) - noise;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    int gap;
    gap = (idle_on && !tail_mode && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      pix_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= pix;
    do @(posedge clk); while (!pix_bus.ready);
    bg_expect.push_back(update_background(pix));
    pixels_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (bg_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_MIN_STEP:     min_step_r = value;
      CFG_EPSILON_GAIN: eps_gain_r = value;
      CFG_FRAME_WIDTH:  width_r    = value[WIDTH_W-1:0];
      CFG_FRAME_HEIGHT: height_r   = value[HEIGHT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // unused upper data bits get random values
  task automatic set_frame_size(int unsigned w, int unsigned h);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FRAME_WIDTH, {junk[CFG_DATA_W-1:WIDTH_W], WIDTH_W'(w)});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FRAME_HEIGHT, {junk[CFG_DATA_W-1:HEIGHT_W], HEIGHT_W'(h)});
  endtask

  task automatic pick_size(output int unsigned w, output int unsigned h);
    case ($urandom_range(0, 19))
      0, 1: begin
        w = 0;
        h = $urandom_range(1, 8);
      end
      2: begin
        w = $urandom_range(1, 8);
        h = 0;
      end
      3: begin
        w = PRIME_W;
        h = PRIME_H;
      end
      4, 5, 6, 7, 8: begin
        w = $urandom_range(1, PRIME_W);
        h = $urandom_range(1, PRIME_H);
      end
      default: begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 4);
      end
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_fix16();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(0, 1024));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // First frame loads the store. Steps start at the min_step extremes, at half
  // a grey level (for rounding ties later) and at zero.
  task automatic test_priming();
    idle_on = 1'b1;
    set_frame_size(PRIME_W, PRIME_H);
    write_reg(CFG_EPSILON_GAIN, 16'd0);
    write_reg(CFG_MIN_STEP, 16'hFFFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    drain_results();
    write_reg(CFG_MIN_STEP, CFG_DATA_W'(1 << (FRAC_BITS - 1)));
    send_pixel(8'h00);
    send_pixel(8'h00);
    drain_results();
    write_reg(CFG_MIN_STEP, 16'd0);
    send_pixel(8'h01);
    send_pixel(8'hAA);
    send_pixel(8'h55);
    drain_results();
    write_reg(CFG_MIN_STEP, 16'h0300);
    while (!primed_flag) send_pixel(scene_pixel(0));
    drain_results();
  endtask

  // 1x6 frames over the first entries: background saturates up and down, and
  // the half-step entries walk through rounding ties on even and on odd grey levels.
  task automatic test_saturation_and_ties();
    set_frame_size(1, 6);
    write_reg(CFG_EPSILON_GAIN, 16'd0);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'hFF);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFF);
    drain_results();
    write_reg(CFG_EPSILON_GAIN, 16'hFFFF);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h00);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFF);
    drain_results();
  endtask

  // Out-of-range and maximal sizes, cut short mid-frame so the counters that
  // lie beyond the smaller size wrap at once.
  task automatic test_size_clamps();
    write_reg(CFG_FRAME_WIDTH, 16'h07FF);
    write_reg(CFG_FRAME_HEIGHT, 16'h03FF);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    send_pixel(8'h80);
    drain_results();
    write_reg(CFG_FRAME_WIDTH, 16'hF801);
    send_pixel(8'h7F);
    send_pixel(8'h3C);
    drain_results();
    write_reg(CFG_FRAME_HEIGHT, 16'hFC00);
    send_pixel(8'hC3);
    drain_results();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
    send_pixel(8'h11);
    send_pixel(8'hEE);
    drain_results();
    write_reg(CFG_FRAME_WIDTH, 16'd0);
    send_pixel(8'h22);
    drain_results();
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    send_pixel(8'hDD);
    drain_results();
  endtask

  // Hold the result side off long enough for the job queue to fill.
  task automatic test_result_backpressure();
    set_frame_size(4, 4);
    idle_on   = 1'b0;
    hold_left = 150;
    repeat (48) send_pixel(scene_pixel(4));
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned count;
    int unsigned frame_px;
    int unsigned w;
    int unsigned h;
    int unsigned tries;
    int unsigned a;
    int          noise;
    bit          noise_phase;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      drain_results();
      tail_mode = (pixels_sent + RANDOM_PIXELS / 8 >= target);
      idle_on   = !tail_mode && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_MIN_STEP, pick_fix16());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_EPSILON_GAIN, pick_fix16());
      if ($urandom_range(0, 1) == 0) begin
        for (tries = 0; tries < 8; tries++) begin
          pick_size(w, h);
          if (sizes_are_safe(w, h)) begin
            set_frame_size(w, h);
            break;
          end
        end
      end
      // let part of the scene change so the estimates have to follow it
      if ($urandom_range(0, 3) == 0)
        for (a = 0; a < SCENE_SIZE; a++)
          if ($urandom_range(0, 3) == 0) scene[a] = PIX_W'($urandom);
      noise       = $urandom_range(0, 12);
      noise_phase = ($urandom_range(0, 5) == 0);
      frame_px    = eff_width(width_r) * eff_height(height_r);
      count       = frame_px * $urandom_range(1, (frame_px >= 300) ? 1 : 300 / frame_px);
      // a ragged phase leaves the next size change in the middle of a frame
      if ($urandom_range(0, 6) == 0) count = $urandom_range(1, frame_px + 3);
      if (count > target - pixels_sent) count = target - pixels_sent;
      repeat (count) begin
        // stop idling on both sides for the last stretch of the run
        tail_mode = (pixels_sent + RANDOM_PIXELS / 8 >= target);
        if (noise_phase) send_pixel(PIX_W'($urandom));
        else send_pixel(scene_pixel(noise));
      end
    end
    drain_results();
  endtask

  // result side: random stall bursts, plus a counted hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && !tail_mode && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beat
    bg_beat_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (bg_expect.size() == 0) begin
        note_error($sformatf("result beat with nothing pending: background %0d frame_end %0b",
                             res_bus.background, res_bus.frame_end));
      end else begin
        want = bg_expect.pop_front();
        if (res_bus.background !== want.background || res_bus.frame_end !== want.frame_end)
          note_error($sformatf("beat %0d: expected background %0d frame_end %0b, got %0d %0b",
                               beats_checked, want.background, want.frame_end,
                               res_bus.background, res_bus.frame_end));
        if (want.frame_end) frames_checked++;
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (pix_bus.valid && !pix_bus.ready && !rst) stalled_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle_count, bg_expect.size());
      $display("fame_background_median_estimator regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int a;
    rst           = 1'b1;
    pix_bus.valid = 1'b0;
    pix_bus.pixel = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_MIN_STEP;
    cfg_bus.data  = '0;
    min_step_r    = RST_MIN_STEP;
    eps_gain_r    = RST_EPSILON_GAIN;
    width_r       = RST_FRAME_WIDTH;
    height_r      = RST_FRAME_HEIGHT;
    col_pos       = 0;
    row_pos       = 0;
    primed_flag   = 1'b0;
    idle_on       = 1'b1;
    tail_mode     = 1'b0;
    for (a = 0; a < SCENE_SIZE; a++) scene[a] = PIX_W'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_priming();
    test_saturation_and_ties();
    test_size_clamps();
    test_result_backpressure();
    test_random_frames();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bg_expect.size() != 0)
      note_error($sformatf("%0d result beats never arrived", bg_expect.size()));
    $display("checked %0d pixels over %0d frames with %0d register writes",
             beats_checked, frames_checked, reg_writes);
    $display("%0d rounding ties, %0d saturated updates, input stalled %0d cycles, %0d errors",
             tie_hits, sat_hits, stalled_cycles, errors);
    if (errors == 0) begin
      $display("fame_background_median_estimator regression: pass");
    end else begin
      $display("fame_background_median_estimator regression: fail");
    end
    $finish;
  end

endmodule
